// File: rtl/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg: shared types and constants of the HTTP header byte parser
// Byte classes, parser states, result codes and the queue entry format.
// ----------------------------------------------------------------------------
package hbp_pkg;

  // Width of the value length limit register.
  localparam int unsigned CfgW = 10;
  localparam logic [CfgW-1:0] CfgReset = 10'd255;

  // Entries of the queue between the classifier and the parser engine.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Characters the parser cares about.
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  // Byte roles.
  localparam logic [1:0] RoleDelim = 2'd0;
  localparam logic [1:0] RoleKey   = 2'd1;
  localparam logic [1:0] RoleValue = 2'd2;
  localparam logic [1:0] RoleBody  = 2'd3;

  // Error codes.
  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrKeyBreak = 3'd1;
  localparam logic [2:0] ErrNoSpace  = 3'd2;
  localparam logic [2:0] ErrTooLong  = 3'd3;
  localparam logic [2:0] ErrLineEnd  = 3'd4;
  localparam logic [2:0] ErrBlank    = 3'd5;

  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_COLON = 3'd1,
    CLS_SPACE = 3'd2,
    CLS_CR    = 3'd3,
    CLS_LF    = 3'd4
  } byte_class_e;

  typedef enum logic [8:0] {
    ST_START  = 9'b000000001,
    ST_KEY    = 9'b000000010,
    ST_COLON  = 9'b000000100,
    ST_SPACE  = 9'b000001000,
    ST_VALUE  = 9'b000010000,
    ST_CR     = 9'b000100000,
    ST_LF     = 9'b001000000,
    ST_END_CR = 9'b010000000,
    ST_END_LF = 9'b100000000
  } parse_state_e;

  // One classified byte as it travels from the front end to the engine.
  typedef struct packed {
    byte_class_e cls;
    logic        new_request;
  } byte_item_t;

endpackage

// File: rtl/http_header_byte_parser.sv
// ----------------------------------------------------------------------------
// http_header_byte_parser: HTTP/1.1 header block byte tagger
// Tags every header byte, flags line and header ends, and latches errors.
// ----------------------------------------------------------------------------
// The block takes one byte per request and returns exactly one result per
// byte, in order, and sustains one byte per clock cycle while the output is
// not stalled. An accepted byte is written into the two-entry classified
// byte queue and its result is then registered by the parser engine, whose
// state machine and value offset counter update once per byte
// and set the rate. The queue and the registered output let input and output
// stall independently. Assert new_request_i with the first byte of a request
// to clear the parser state, value offset and latched error before that byte
// is used. Once an error is latched every following byte is tagged as a
// delimiter and carries the error code until the next new request. The value
// length limit is written through cfg_we_i and cfg_data_i; change it only
// while no request is in flight. OFFSET_LIMIT sets where the internal value
// offset counter saturates.
// ----------------------------------------------------------------------------
module http_header_byte_parser #(
  parameter int unsigned OFFSET_LIMIT = 1023
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write port for the value length limit.
  input  logic                     cfg_we_i,
  input  logic [hbp_pkg::CfgW-1:0] cfg_data_i,
  // Input byte channel.
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     new_request_i,
  // Result channel.
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               byte_role_o,
  output logic                     line_done_o,
  output logic                     headers_done_o,
  output logic [2:0]               error_code_o
);
  import hbp_pkg::*;

  logic [CfgW-1:0] max_value_offset_q;
  logic            push, full, pop, queued_valid;
  byte_item_t      front_item, queued_item;

  // Value length limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_offset_q <= CfgReset;
    end else if (cfg_we_i) begin
      max_value_offset_q <= cfg_data_i;
    end
  end

  // Front end: classify each byte as it is accepted.
  hbp_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .new_request_i (new_request_i),
    .push_o        (push),
    .item_o        (front_item),
    .full_i        (full)
  );

  // Decoupling queue between classifier and engine.
  hbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queued_valid),
    .item_o  (queued_item)
  );

  // Back end: header state machine and registered results.
  hbp_back #(
    .OFFSET_LIMIT (OFFSET_LIMIT)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_valid_i       (queued_valid),
    .item_i             (queued_item),
    .pop_o              (pop),
    .max_value_offset_i (max_value_offset_q),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .byte_role_o        (byte_role_o),
    .line_done_o        (line_done_o),
    .headers_done_o     (headers_done_o),
    .error_code_o       (error_code_o)
  );

endmodule

// File: rtl/hbp_front.sv
// ----------------------------------------------------------------------------
// hbp_front: input classifier
// Accepts raw bytes and reduces each one to its character class.
// ----------------------------------------------------------------------------
module hbp_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               new_request_i,
  output logic               push_o,
  output hbp_pkg::byte_item_t item_o,
  input  logic               full_i
);
  import hbp_pkg::*;

  byte_class_e cls;

  always_comb begin
    if (data_byte_i == ChColon) begin
      cls = CLS_COLON;
    end else if (data_byte_i == ChSpace) begin
      cls = CLS_SPACE;
    end else if (data_byte_i == ChCr) begin
      cls = CLS_CR;
    end else if (data_byte_i == ChLf) begin
      cls = CLS_LF;
    end else begin
      cls = CLS_OTHER;
    end
  end

  // The queue alone decides whether a request can be taken.
  assign in_stall_o         = full_i;
  assign push_o             = in_valid_i && !full_i;
  assign item_o.cls         = cls;
  assign item_o.new_request = new_request_i;

endmodule

// File: rtl/hbp_queue.sv
// ----------------------------------------------------------------------------
// hbp_queue: classified byte queue
// Short first-in first-out buffer that decouples classifier and engine.
// ----------------------------------------------------------------------------
module hbp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hbp_pkg::byte_item_t item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output hbp_pkg::byte_item_t item_o
);
  import hbp_pkg::*;

  byte_item_t                 entry_q [QueueDepth];
  logic [QueuePtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]       count_q, count_d;
  logic                       do_push, do_pop;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: rtl/hbp_back.sv
// ----------------------------------------------------------------------------
// hbp_back: parser engine
// Runs the header state machine on classified bytes and registers results.
// ----------------------------------------------------------------------------
module hbp_back #(
  parameter int unsigned OFFSET_LIMIT = 1023
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  input  hbp_pkg::byte_item_t      item_i,
  output logic                     pop_o,
  input  logic [hbp_pkg::CfgW-1:0] max_value_offset_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               byte_role_o,
  output logic                     line_done_o,
  output logic                     headers_done_o,
  output logic [2:0]               error_code_o
);
  import hbp_pkg::*;

  localparam int unsigned OffW = $clog2(OFFSET_LIMIT + 1);
  localparam int unsigned CmpW = (OffW > CfgW) ? OffW : CfgW;
  localparam logic [OffW-1:0] OffLimit = OffW'(OFFSET_LIMIT);

  parse_state_e    state_q, state_d, state_cur;
  logic [OffW-1:0] offset_q, offset_d, offset_cur, offset_inc;
  logic [2:0]      error_q, error_d;
  logic [1:0]      role_d;
  logic            line_d, hdone_d;
  logic            out_valid_q;
  logic [1:0]      role_q;
  logic            line_q, hdone_q;
  logic [2:0]      code_q;

  // A result is produced whenever an item is queued and the output register is free or drained.
  assign pop_o = item_valid_i && (!out_valid_q || !out_stall_i);

  assign offset_inc = (offset_cur < OffLimit) ? offset_cur + 1'b1 : offset_cur;

  always_comb begin
    state_cur  = item_i.new_request ? ST_START : state_q;
    offset_cur = item_i.new_request ? '0 : offset_q;
    error_d    = item_i.new_request ? ErrNone : error_q;
    state_d    = state_cur;
    offset_d   = offset_cur;
    role_d     = RoleDelim;
    line_d     = 1'b0;
    hdone_d    = 1'b0;
    if (error_d == ErrNone) begin
      case (state_cur)
        ST_KEY: begin
          if (item_i.cls == CLS_COLON) begin
            state_d = ST_COLON;
          end else if (item_i.cls == CLS_CR || item_i.cls == CLS_LF) begin
            error_d = ErrKeyBreak;
          end else begin
            role_d = RoleKey;
          end
        end
        ST_COLON: begin
          if (item_i.cls == CLS_SPACE) begin
            state_d = ST_SPACE;
          end else begin
            error_d = ErrNoSpace;
          end
        end
        ST_SPACE: begin
          offset_d = '0;
          role_d   = RoleValue;
          state_d  = ST_VALUE;
        end
        ST_VALUE: begin
          if (item_i.cls == CLS_CR) begin
            state_d = ST_CR;
          end else begin
            offset_d = offset_inc;
            if (CmpW'(offset_inc) > CmpW'(max_value_offset_i)) begin
              error_d = ErrTooLong;
            end else begin
              role_d = RoleValue;
            end
          end
        end
        ST_CR: begin
          if (item_i.cls == CLS_LF) begin
            line_d  = 1'b1;
            state_d = ST_LF;
          end else begin
            error_d = ErrLineEnd;
          end
        end
        ST_LF: begin
          if (item_i.cls == CLS_CR) begin
            state_d = ST_END_CR;
          end else begin
            role_d  = RoleKey;
            state_d = ST_KEY;
          end
        end
        ST_END_CR: begin
          if (item_i.cls == CLS_LF) begin
            hdone_d = 1'b1;
            state_d = ST_END_LF;
          end else begin
            error_d = ErrBlank;
          end
        end
        ST_END_LF: begin
          role_d = RoleBody;
        end
        default: begin
          if (item_i.cls != CLS_CR && item_i.cls != CLS_LF) begin
            role_d  = RoleKey;
            state_d = ST_KEY;
          end else begin
            state_d = ST_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      offset_q    <= '0;
      error_q     <= ErrNone;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        state_q     <= state_d;
        offset_q    <= offset_d;
        error_q     <= error_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      role_q  <= role_d;
      line_q  <= line_d;
      hdone_q <= hdone_d;
      code_q  <= error_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_role_o    = role_q;
  assign line_done_o    = line_q;
  assign headers_done_o = hdone_q;
  assign error_code_o   = code_q;

endmodule

// File: rtl/hbp_checker.sv
// ----------------------------------------------------------------------------
// hbp_checker: port level checks for the header byte parser
// Watches the result channel and checks result consistency over time.
// ----------------------------------------------------------------------------
module hbp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] byte_role_o,
  input logic       line_done_o,
  input logic       headers_done_o,
  input logic [2:0] error_code_o
);
  import hbp_pkg::*;

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_role_o) &&
      $stable(line_done_o) && $stable(headers_done_o) && $stable(error_code_o))
    else $error("stalled result changed");

  // A byte that carries an error is never tagged or flagged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ErrNone |->
      byte_role_o == RoleDelim && !line_done_o && !headers_done_o)
    else $error("error result with role or flags");

  // One LF cannot end both a header line and the header block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(line_done_o && headers_done_o))
    else $error("line and headers done together");

  // Flags only appear on delimiter bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (line_done_o || headers_done_o) |-> byte_role_o == RoleDelim)
    else $error("done flag on a tagged byte");

  // Error codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_code_o <= ErrBlank)
    else $error("undefined error code");

endmodule

bind http_header_byte_parser hbp_checker u_hbp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .byte_role_o    (byte_role_o),
  .line_done_o    (line_done_o),
  .headers_done_o (headers_done_o),
  .error_code_o   (error_code_o)
);
